// ===== design/vatf_pkg.sv =====
// Package for the vertex attribute to float converter.
// Holds payload structs, format codes and the float conversion helper.
// No dependencies.
package vatf_pkg;

   localparam int MaxComponents = 4;

   typedef enum logic [3:0] {
      FMT_S8 = 4'd0, FMT_U8 = 4'd1, FMT_S16 = 4'd2, FMT_U16 = 4'd3,
      FMT_S32 = 4'd4, FMT_U32 = 4'd5, FMT_HALF = 4'd6, FMT_FLOAT = 4'd7,
      FMT_DOUBLE = 4'd8
   } fmt_type;

   typedef enum logic [2:0] {
      REG_SRC_FORMAT = 3'd0, REG_SRC_COMPONENTS = 3'd1, REG_OUT_COMPONENTS = 3'd2,
      REG_DEFAULT_0 = 3'd3, REG_DEFAULT_1 = 3'd4, REG_DEFAULT_2 = 3'd5,
      REG_DEFAULT_3 = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic [63:0] raw_0;
      logic [63:0] raw_1;
      logic [63:0] raw_2;
      logic [63:0] raw_3;
      logic        vertex_last;
   } req_type;

   typedef struct packed {
      logic [31:0] result_0;
      logic [31:0] result_1;
      logic [31:0] result_2;
      logic [31:0] result_3;
      logic        result_last;
   } rsp_type;

   // Stage 1 to stage 2 record of one lane.
   typedef struct packed {
      logic        pass;      // value is final bits in pass_bits
      logic [31:0] pass_bits;
      logic        sign;
      logic        zero;
      logic [8:0]  exp;       // biased exponent of the rounded magnitude
      logic [23:0] mant;      // rounded significand with hidden bit
      logic        mul;       // multiply by reciprocal needed
      logic [23:0] recip;     // reciprocal significand
      logic [8:0]  rexp;      // reciprocal biased exponent
   } lane_mid_type;

   // Round a 64-bit magnitude with leading one at position pos (counted from bit 0)
   // to 24 bits, round to nearest even. Returns {1'b0, carry-adjusted mant, exp}.
   function automatic logic [33:0] round_int(input logic [63:0] mag);
      logic [5:0]  pos;
      logic [63:0] norm;
      logic [24:0] m;
      logic        g, st;
      logic [8:0]  e;
      pos = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) pos = 6'(i);
      end
      norm = mag << (6'd63 - pos);
      g = norm[39];
      st = |norm[38:0];
      m = {1'b0, norm[63:40]} + 25'((g && (st || norm[40])) ? 1 : 0);
      e = 9'(127) + 9'(pos);
      if (m[24]) begin
         m = m >> 1;
         e = e + 9'd1;
      end
      return {1'b0, m[23:0], e};
   endfunction

endpackage

// ===== design/vatf_lane.sv =====
// One conversion lane: converts a raw component to float32 bits in two stages.
// Depends on vatf_pkg.
module vatf_lane (
   input  logic        clock,
   input  logic        enable,
   input  logic [3:0]  fmt,
   input  logic [63:0] raw,
   output logic [31:0] result
);
   import vatf_pkg::*;

   lane_mid_type mid_in, mid_ff;
   logic [31:0]  result_in, result_ff;

   always_comb begin
      logic [63:0] mag;
      logic [33:0] r;
      logic [10:0] dex;
      logic [51:0] dman;
      logic [24:0] dm;
      logic        g, st;
      logic signed [12:0] fe;
      logic [76:0] sub;
      mid_in = '0;
      mag = '0;
      r = '0;
      dm = '0;
      g = 1'b0;
      st = 1'b0;
      sub = '0;
      dex = raw[62:52];
      dman = raw[51:0];
      fe = 13'(dex) - 13'sd896;
      case (fmt)
         FMT_S8, FMT_S16, FMT_S32: begin
            mid_in.sign = (fmt == FMT_S8) ? raw[7] : (fmt == FMT_S16) ? raw[15] : raw[31];
            if (fmt == FMT_S8) mag = 64'(mid_in.sign ? 8'(-raw[7:0]) : raw[7:0]);
            else if (fmt == FMT_S16) mag = 64'(mid_in.sign ? 16'(-raw[15:0]) : raw[15:0]);
            else mag = 64'(mid_in.sign ? 32'(-raw[31:0]) : raw[31:0]);
            if (fmt == FMT_S8) begin
               mag = (mid_in.sign && raw[7:0] == 8'h80) ? 64'd128 : mag;
            end else if (fmt == FMT_S16) begin
               mag = (mid_in.sign && raw[15:0] == 16'h8000) ? 64'd32768 : mag;
            end else begin
               mag = (mid_in.sign && raw[31:0] == 32'h80000000) ? 64'h80000000 : mag;
            end
         end
         FMT_U8:  mag = 64'(raw[7:0]);
         FMT_U16: mag = 64'(raw[15:0]);
         FMT_U32: mag = 64'(raw[31:0]);
         default: mag = '0;
      endcase
      r = round_int(mag);
      mid_in.zero = (mag == '0);
      mid_in.mant = r[32:9];
      mid_in.exp = r[8:0];
      case (fmt)
         FMT_S8:  begin mid_in.mul = 1'b1; mid_in.recip = 24'h810204; mid_in.rexp = 9'd120; end
         FMT_U8:  begin mid_in.mul = 1'b1; mid_in.recip = 24'h808081; mid_in.rexp = 9'd119; end
         FMT_S16: begin mid_in.mul = 1'b1; mid_in.recip = 24'h800100; mid_in.rexp = 9'd112; end
         FMT_U16: begin mid_in.mul = 1'b1; mid_in.recip = 24'h800080; mid_in.rexp = 9'd111; end
         FMT_S32: mid_in.exp = mid_in.zero ? 9'd0 : mid_in.exp - 9'd31;
         FMT_U32: begin
            // u / 4294967295f where divisor rounds to 2^32.
            mid_in.exp = mid_in.zero ? 9'd0 : mid_in.exp - 9'd32;
         end
         FMT_FLOAT: begin
            mid_in.pass = 1'b1;
            mid_in.pass_bits = raw[31:0];
         end
         default: begin
            mid_in.pass = 1'b1;
            if (dex == 11'h7ff) begin
               mid_in.pass_bits = (dman != '0)
                  ? {raw[63], 8'hff, 1'b1, dman[50:29]} : {raw[63], 31'h7f800000};
            end else if (dex == '0) begin
               mid_in.pass_bits = {raw[63], 31'd0};
            end else if (fe >= 13'sd255) begin
               mid_in.pass_bits = {raw[63], 31'h7f800000};
            end else if (fe >= 13'sd1) begin
               g = dman[28];
               st = |dman[27:0];
               dm = {2'b01, dman[51:29]} + 25'((g && (st || dman[29])) ? 1 : 0);
               mid_in.pass_bits = {raw[63], 8'(fe), dm[22:0]};
               if (dm[24]) mid_in.pass_bits = {raw[63], 8'(fe + 13'sd1), 23'd0};
            end else if (fe >= -13'sd24) begin
               sub = {1'b1, dman, 24'd0} >> (13'sd1 - fe);
               g = sub[52];
               st = |sub[51:0];
               dm = 25'(sub[76:53]) + 25'((g && (st || sub[53])) ? 1 : 0);
               mid_in.pass_bits = {raw[63], 31'(dm)};
            end else begin
               mid_in.pass_bits = {raw[63], 31'd0};
            end
         end
      endcase
   end

   always_comb begin
      logic [47:0] p;
      logic [24:0] m;
      logic [9:0]  e;
      logic        g, st;
      p = mid_ff.mant * mid_ff.recip;
      e = 10'(mid_ff.exp) + 10'(mid_ff.rexp) - 10'd127;
      if (p[47]) begin
         g = p[23];
         st = |p[22:0];
         m = {1'b0, p[47:24]} + 25'((g && (st || p[24])) ? 1 : 0);
         e = e + 10'd1;
      end else begin
         g = p[22];
         st = |p[21:0];
         m = {1'b0, p[46:23]} + 25'((g && (st || p[23])) ? 1 : 0);
      end
      if (m[24]) e = e + 10'd1;
      if (mid_ff.pass) begin
         result_in = mid_ff.pass_bits;
      end else if (mid_ff.zero) begin
         result_in = 32'd0;
      end else if (mid_ff.mul) begin
         result_in = {mid_ff.sign, e[7:0], m[22:0]};
      end else begin
         result_in = {mid_ff.sign, mid_ff.exp[7:0], mid_ff.mant[22:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mid_ff <= mid_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;
endmodule

// ===== design/vertex_attribute_to_float.sv =====
// Top level of the vertex attribute to float converter.
// Depends on vatf_pkg and vatf_lane.
//
// Channel | Ports                         | Role
// req     | req_valid req_ready req_data  | raw vertex in
// rsp     | rsp_valid rsp_ready rsp_data  | float32 vertex out
// csr     | csr_we csr_index csr_data     | register writes
//
// One item per cycle while the output is not stalled; four lanes of two stages.
// The pipeline advances whenever its output stage is empty or being taken.
// Reset clears the valid bits and the registers to their reset values.
module vertex_attribute_to_float (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  vatf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output vatf_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [2:0]        csr_index,
   input  logic [31:0]       csr_data
);
   import vatf_pkg::*;

   logic [3:0]  fmt_ff;
   logic [2:0]  nsrc_ff, nout_ff;
   logic [31:0] dflt_ff [MaxComponents];
   logic        v1_ff, v2_ff, v1_in, v2_in, advance;
   logic [1:0]  last_ff;
   logic [63:0] raw [MaxComponents];
   logic [31:0] conv [MaxComponents];
   logic [3:0]  use1_ff, use2_ff, live1_ff, live2_ff, use_in, live_in;
   logic [2:0]  nsrc, nout;
   logic        known;

   assign advance = !v2_ff || rsp_ready;
   assign req_ready = advance;
   assign v1_in = req_valid;
   assign v2_in = v1_ff;
   assign raw[0] = req_data.raw_0;
   assign raw[1] = req_data.raw_1;
   assign raw[2] = req_data.raw_2;
   assign raw[3] = req_data.raw_3;
   assign known = (fmt_ff <= FMT_DOUBLE) && (fmt_ff != FMT_HALF);
   assign nsrc = !known ? 3'd0 : (nsrc_ff > 3'd4 ? 3'd4 : nsrc_ff);
   assign nout = nout_ff > 3'd4 ? 3'd4 : nout_ff;

   always_comb begin
      for (int j = 0; j < MaxComponents; j++) begin
         live_in[j] = 3'(j) < nout;
         use_in[j] = 3'(j) < nsrc;
      end
   end

   for (genvar j = 0; j < MaxComponents; j++) begin : g_lane
      vatf_lane u_lane (
         .clock  (clock),
         .enable (advance),
         .fmt    (fmt_ff),
         .raw    (raw[j]),
         .result (conv[j])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff <= FMT_FLOAT;
         nsrc_ff <= '0;
         nout_ff <= 3'd4;
         for (int j = 0; j < MaxComponents; j++) dflt_ff[j] <= '0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_SRC_FORMAT:     fmt_ff <= csr_data[3:0];
               REG_SRC_COMPONENTS: nsrc_ff <= csr_data[2:0];
               REG_OUT_COMPONENTS: nout_ff <= csr_data[2:0];
               REG_DEFAULT_0:      dflt_ff[0] <= csr_data;
               REG_DEFAULT_1:      dflt_ff[1] <= csr_data;
               REG_DEFAULT_2:      dflt_ff[2] <= csr_data;
               REG_DEFAULT_3:      dflt_ff[3] <= csr_data;
               default: ;
            endcase
         end
         if (advance) begin
            v1_ff <= v1_in;
            v2_ff <= v2_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         use1_ff <= use_in;
         live1_ff <= live_in;
         use2_ff <= use1_ff;
         live2_ff <= live1_ff;
         last_ff <= {last_ff[0], req_data.vertex_last};
      end
   end

   always_comb begin
      logic [31:0] v [MaxComponents];
      for (int j = 0; j < MaxComponents; j++) begin
         v[j] = !live2_ff[j] ? 32'd0 : (use2_ff[j] ? conv[j] : dflt_ff[j]);
      end
      rsp_data.result_0 = v[0];
      rsp_data.result_1 = v[1];
      rsp_data.result_2 = v[2];
      rsp_data.result_3 = v[3];
      rsp_data.result_last = last_ff[1];
   end

   assign rsp_valid = v2_ff;
endmodule

// ===== bench/vertex_attribute_to_float_tb.sv =====
// Self-checking testbench for vertex_attribute_to_float.
// Drives raw vertices through phases of register settings and compares every
// float32 vertex with its own predictor. Depends on vatf_pkg and the block.
module vertex_attribute_to_float_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import vatf_pkg::*;

   localparam int StallLimit = 5000;
   localparam int PhaseCount = 12;
   localparam int ItemsPerPhase = 70;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   req_type     pending_vertices[$];
   rsp_type     expected_vertices[$];
   int          send_idle_pct = 0;
   int          recv_idle_pct = 0;
   int          mismatch_count = 0;
   int          stall_cycles = 0;

   logic [3:0]  cfg_format;
   logic [2:0]  cfg_src_count;
   logic [2:0]  cfg_out_count;
   logic [31:0] cfg_default[4];
   logic [31:0] recip_127, recip_255, recip_32767, recip_65535;

   vertex_attribute_to_float u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   // Round the value of a double bit pattern to float32 bits, nearest even.
   function automatic logic [31:0] round_to_f32(input logic [63:0] d);
      logic [63:0] sig, kept, rem, half, base;
      int          fe, sh;
      if (d[62:52] == 11'h7ff) return {d[63], 31'h7f800000};
      sig = (d[62:52] == 0) ? {12'b0, d[51:0]} : {11'b0, 1'b1, d[51:0]};
      fe = ((d[62:52] == 0) ? 1 : int'(d[62:52])) - 1023 + 127;
      if (fe >= 255) return {d[63], 31'h7f800000};
      sh = (fe >= 1) ? 29 : 30 - fe;
      if (sh > 60) sh = 60;
      kept = sig >> sh;
      rem = sig & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      base = (fe >= 1) ? ((64'(fe - 1) << 23) + kept) : kept;
      if (rem > half || (rem == half && kept[0])) base = base + 64'd1;
      if (base >= 64'h7f800000) base = 64'h7f800000;
      return {d[63], base[30:0]};
   endfunction

   // Value of a normal or zero float32 pattern.
   function automatic real f32_value(input logic [31:0] b);
      logic [10:0] e;
      if (b[30:0] == 0) return 0.0;
      e = 11'(b[30:23]) - 11'd127 + 11'd1023;
      return $bitstoreal({b[31], e, b[22:0], 29'd0});
   endfunction

   function automatic logic [31:0] real_to_f32(input real r);
      return round_to_f32($realtobits(r));
   endfunction

   function automatic logic [31:0] convert_component(input logic [63:0] raw);
      logic [31:0] whole;
      case (fmt_type'(cfg_format))
         FMT_S8:  return real_to_f32(real'(int'($signed(raw[7:0]))) * f32_value(recip_127));
         FMT_U8:  return real_to_f32(real'(int'(raw[7:0])) * f32_value(recip_255));
         FMT_S16: return real_to_f32(real'(int'($signed(raw[15:0]))) * f32_value(recip_32767));
         FMT_U16: return real_to_f32(real'(int'(raw[15:0])) * f32_value(recip_65535));
         FMT_S32: begin
            whole = real_to_f32(real'(int'($signed(raw[31:0]))));
            return real_to_f32(f32_value(whole) / 2147483648.0);
         end
         FMT_U32: begin
            whole = real_to_f32(real'(longint'({32'b0, raw[31:0]})));
            return real_to_f32(f32_value(whole) / 4294967296.0);
         end
         FMT_FLOAT: return raw[31:0];
         default: begin
            if (raw[62:52] == 11'h7ff && raw[51:0] != 0)
               return {raw[63], 9'h1ff, raw[50:29]};
            return round_to_f32(raw);
         end
      endcase
   endfunction

   function automatic rsp_type predict_vertex(input req_type v);
      rsp_type     r;
      logic [63:0] raws[4];
      logic [31:0] outs[4];
      int          nsrc, nout;
      raws = '{v.raw_0, v.raw_1, v.raw_2, v.raw_3};
      nsrc = (cfg_src_count > 4) ? 4 : int'(cfg_src_count);
      nout = (cfg_out_count > 4) ? 4 : int'(cfg_out_count);
      if (cfg_format > FMT_DOUBLE || cfg_format == FMT_HALF) nsrc = 0;
      for (int j = 0; j < 4; j++) begin
         outs[j] = '0;
         if (j < nout) outs[j] = (j < nsrc) ? convert_component(raws[j]) : cfg_default[j];
      end
      r.result_0 = outs[0];
      r.result_1 = outs[1];
      r.result_2 = outs[2];
      r.result_3 = outs[3];
      r.result_last = v.vertex_last;
      return r;
   endfunction

   function automatic logic [63:0] pick_raw();
      case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return 64'h80 << (8 * $urandom_range(3));
         3: return 64'h7f << (8 * $urandom_range(3)) | ((64'h1 << (8 * $urandom_range(3))) - 1);
         4: return {1'($urandom), 11'h7ff, 20'($urandom), 32'($urandom & {32{$urandom_range(1)}})};
         5: return {1'($urandom), 11'($urandom_range(1023)), 20'($urandom), 32'($urandom)};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic req_type random_vertex();
      req_type v;
      v.raw_0 = pick_raw();
      v.raw_1 = pick_raw();
      v.raw_2 = pick_raw();
      v.raw_3 = pick_raw();
      v.vertex_last = 1'($urandom);
      return v;
   endfunction

   task automatic write_reg(input reg_index_type idx, input logic [31:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      case (idx)
         REG_SRC_FORMAT:     cfg_format = value[3:0];
         REG_SRC_COMPONENTS: cfg_src_count = value[2:0];
         REG_OUT_COMPONENTS: cfg_out_count = value[2:0];
         default:            cfg_default[int'(idx) - 3] = value;
      endcase
   endtask

   task automatic wait_drained();
      while (pending_vertices.size() != 0 || expected_vertices.size() != 0 || req_valid)
         @(posedge clock);
   endtask

   // Sender: a new item is offered only once the previous one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_vertices.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_data <= pending_vertices.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver, checker and watchdog.
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (req_valid && req_ready) expected_vertices.push_back(predict_vertex(req_data));
         if (rsp_valid && rsp_ready) begin
            if (expected_vertices.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10) $display("unexpected vertex %h", rsp_data);
            end else begin
               want = expected_vertices.pop_front();
               if (want != rsp_data) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("vertex mismatch: expected %h %h %h %h %b, got %h %h %h %h %b",
                        want.result_0, want.result_1, want.result_2, want.result_3,
                        want.result_last, rsp_data.result_0, rsp_data.result_1,
                        rsp_data.result_2, rsp_data.result_3, rsp_data.result_last);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            stall_cycles <= 0;
         end else if (stall_cycles + 1 >= StallLimit) begin
            $display("FAIL vertex_attribute_to_float");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   initial begin
      int fmts[PhaseCount] = '{7, 0, 1, 2, 3, 4, 5, 6, 8, 15, 9, 8};
      int srcs[PhaseCount] = '{4, 4, 2, 3, 1, 4, 4, 7, 4, 4, 0, 5};
      int outs[PhaseCount] = '{4, 3, 4, 4, 2, 0, 4, 7, 1, 4, 4, 6};
      req_type v;
      recip_127 = real_to_f32(1.0 / 127.0);
      recip_255 = real_to_f32(1.0 / 255.0);
      recip_32767 = real_to_f32(1.0 / 32767.0);
      recip_65535 = real_to_f32(1.0 / 65535.0);
      cfg_format = FMT_FLOAT;
      cfg_src_count = 3'd0;
      cfg_out_count = 3'd4;
      for (int j = 0; j < 4; j++) cfg_default[j] = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < PhaseCount; p++) begin
         wait_drained();
         repeat (4) @(posedge clock);
         send_idle_pct = (p < 4) ? 22 : (p < 8) ? 65 : 0;
         recv_idle_pct = (p < 4) ? 65 : (p < 8) ? 22 : 0;
         write_reg(REG_SRC_FORMAT, 32'(fmts[p]));
         write_reg(REG_SRC_COMPONENTS, 32'(srcs[p]));
         write_reg(REG_OUT_COMPONENTS, 32'(outs[p]));
         for (int j = 0; j < 4; j++)
            write_reg(reg_index_type'(3 + j),
               (p == 0) ? 32'h0 : (p == 1) ? 32'hffffffff : $urandom);
         @(posedge clock);
         csr_we <= 1'b0;
         if (p == 0) begin
            for (int k = 0; k < 16; k++) begin
               v.raw_0 = (k[0]) ? '1 : '0;
               v.raw_1 = 64'h80000000 >> (8 * (k % 4));
               v.raw_2 = 64'h7fffffff >> (8 * (k % 4));
               v.raw_3 = {1'(k[1]), 11'h7ff, 1'(k[2]), 51'(k[3])};
               v.vertex_last = k[0];
               pending_vertices.push_back(v);
            end
         end
         for (int k = 0; k < ItemsPerPhase; k++) begin
            if (p == 2 && k == ItemsPerPhase / 2) wait_drained();
            pending_vertices.push_back(random_vertex());
         end
      end
      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("PASS vertex_attribute_to_float");
      end else begin
         $display("FAIL vertex_attribute_to_float");
      end
      $finish;
   end

endmodule
